// ===== src/pwf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwf_pkg: shared types and constants of the polyphase window framer
// Field layouts, command and state codes, and the fixed sizes of the ring,
// the window table and the arithmetic.
// ----------------------------------------------------------------------------
package pwf_pkg;

   // Frame and ring geometry. The width of coef_index follows from it.
   localparam int FRAME_SIZE = 1024;
   localparam int TAPS       = 8;
   localparam int RING_LEN   = FRAME_SIZE * TAPS;
   localparam int FRAME_AW   = $clog2(FRAME_SIZE);
   localparam int TAP_AW     = $clog2(TAPS);
   localparam int RING_AW    = $clog2(RING_LEN);

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 4;

   // Arithmetic widths.
   localparam int SAMPLE_W    = 16;
   localparam int PROD_W      = 2 * SAMPLE_W;
   localparam int ACC_W       = PROD_W + TAP_AW;
   localparam int OUT_W       = 20;
   localparam int POS_W       = 10;
   localparam int ROUND_SHIFT = 15;
   localparam int ROUND_HALF  = 1 << (ROUND_SHIFT - 1);
   localparam int OUT_MAX     = 524287;
   localparam int OUT_MIN     = -524288;

   // Operation codes of the op field.
   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_COEF = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // Frame mode register codes.
   localparam int         MODE_W      = 2;
   localparam logic [1:0] MODE_RAW    = 2'd0;
   localparam logic [1:0] MODE_WINDOW = 2'd1;
   localparam logic [1:0] MODE_POLY   = 2'd2;

   // Input item as seen on the request port.
   typedef struct packed {
      logic [1:0]                  op;
      logic signed [SAMPLE_W-1:0]  sample_re;
      logic signed [SAMPLE_W-1:0]  sample_im;
      logic [RING_AW-1:0]          coef_index;
      logic signed [SAMPLE_W-1:0]  coef_value;
      logic [POS_W-1:0]            frame_index;
   } pwf_req_type;

   // Result item as seen on the response port.
   typedef struct packed {
      logic signed [OUT_W-1:0] out_re;
      logic signed [OUT_W-1:0] out_im;
      logic [POS_W-1:0]        out_position;
   } pwf_rsp_type;

   // Command classes held in the queue.
   typedef enum logic [1:0] {
      KIND_PUSH,
      KIND_COEF,
      KIND_READ
   } pwf_kind_type;

   // One queued command. For a coefficient write data_re carries the value.
   typedef struct packed {
      pwf_kind_type               kind;
      logic signed [SAMPLE_W-1:0] data_re;
      logic signed [SAMPLE_W-1:0] data_im;
      logic [RING_AW-1:0]         addr;
   } pwf_cmd_type;

   // Head of the queue as offered to the back end.
   typedef struct packed {
      logic        valid;
      pwf_cmd_type cmd;
   } pwf_queue_type;

   // Back end status returned to the front end.
   typedef struct packed {
      logic pop;
      logic clearing;
   } pwf_back_status_type;

   // Back end sequencer states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_FLUSH
   } pwf_back_state_type;

endpackage

// ===== src/pwf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwf_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pwf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pwf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwf_front: request intake and command queue
// Accepts request transfers, classifies them by operation and queues them
// in order for the back end. Unused operation codes are dropped here.
// ----------------------------------------------------------------------------
module pwf_front #(
   parameter int QUEUE_DEPTH = pwf_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  pwf_pkg::pwf_req_type         req_item,
   output logic                         busy,
   output pwf_pkg::pwf_queue_type       queue,
   input  pwf_pkg::pwf_back_status_type status
);

   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);

   pwf_pkg::pwf_cmd_type entries_ff [QUEUE_DEPTH];
   logic [QAW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]        count_ff, count_in;
   pwf_pkg::pwf_cmd_type cmd;
   logic                 accept;
   logic                 enq;
   logic                 op_known;

   // The front stalls when the queue is full or the ring is being cleared.
   assign busy   = (count_ff == CW'(QUEUE_DEPTH)) || status.clearing;
   assign accept = start && !busy;
   assign enq    = accept && op_known;

   // Classify the request into a queue command.
   always_comb begin
      cmd.kind    = pwf_pkg::KIND_PUSH;
      cmd.data_re = req_item.sample_re;
      cmd.data_im = req_item.sample_im;
      cmd.addr    = '0;
      op_known    = 1'b1;
      unique case (req_item.op)
         pwf_pkg::OP_PUSH: begin
            cmd.kind = pwf_pkg::KIND_PUSH;
         end
         pwf_pkg::OP_COEF: begin
            cmd.kind    = pwf_pkg::KIND_COEF;
            cmd.data_re = req_item.coef_value;
            cmd.addr    = req_item.coef_index;
         end
         pwf_pkg::OP_READ: begin
            cmd.kind = pwf_pkg::KIND_READ;
            cmd.addr = pwf_pkg::RING_AW'(req_item.frame_index);
         end
         default: begin
            op_known = 1'b0;
         end
      endcase
   end

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (status.pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(enq) - CW'(status.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (enq) begin
         entries_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign queue.valid = (count_ff != '0);
   assign queue.cmd   = entries_ff[rd_ptr_ff];

   // The back end never takes a command from an empty queue.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      status.pop |-> (count_ff != '0))
      else $error("pop from an empty command queue");

   // An empty queue has its pointers together.
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers apart while empty");

endmodule

// ===== src/pwf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwf_back: ring and window execution unit
// Clears the ring after reset, then executes queued pushes, coefficient
// writes and frame reads. A read issues one tap per cycle to the ring and
// window memories and accumulates the products in a multiply pipeline.
// ----------------------------------------------------------------------------
module pwf_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [pwf_pkg::MODE_W-1:0]   frame_mode,
   input  pwf_pkg::pwf_queue_type       queue,
   output pwf_pkg::pwf_back_status_type status,
   output logic                         rsp_valid,
   output pwf_pkg::pwf_rsp_type         rsp_item
);

   localparam int SW      = pwf_pkg::SAMPLE_W;
   localparam int RAW     = pwf_pkg::RING_AW;
   localparam int FAW     = pwf_pkg::FRAME_AW;
   localparam int TAW     = pwf_pkg::TAP_AW;
   localparam int PW      = pwf_pkg::PROD_W;
   localparam int AW      = pwf_pkg::ACC_W;
   localparam int OW      = pwf_pkg::OUT_W;
   localparam int SCALE_W = AW + 1 - pwf_pkg::ROUND_SHIFT;

   // Round a Q5.30 sum to Q5.15 with halves upward, then saturate.
   function automatic logic signed [OW-1:0] pwf_round_sat(input logic signed [AW-1:0] acc);
      logic signed [AW:0]        rounded;
      logic signed [SCALE_W-1:0] scaled;
      rounded = {acc[AW-1], acc} + (AW + 1)'(pwf_pkg::ROUND_HALF);
      scaled  = rounded[AW:pwf_pkg::ROUND_SHIFT];
      if (scaled > SCALE_W'(pwf_pkg::OUT_MAX)) begin
         return OW'(pwf_pkg::OUT_MAX);
      end else if (scaled < SCALE_W'(pwf_pkg::OUT_MIN)) begin
         return OW'(pwf_pkg::OUT_MIN);
      end else begin
         return OW'(scaled);
      end
   endfunction

   pwf_pkg::pwf_back_state_type state_ff, state_in;
   logic [RAW-1:0]          clr_ff, clr_in;
   logic [RAW-1:0]          fp_ff, fp_in;
   logic [TAW-1:0]          tap_ff, tap_in;
   logic [RAW-1:0]          j_ff, j_in;
   logic [FAW-1:0]          pos_ff, pos_in;
   logic                    raw_ff, raw_in;
   logic                    rpoly_ff, rpoly_in;
   logic                    rd_v_ff, rd_v_in;
   logic                    prod_v_ff, prod_v_in;
   logic signed [PW-1:0]    prod_re_ff, prod_re_in;
   logic signed [PW-1:0]    prod_im_ff, prod_im_in;
   logic signed [AW-1:0]    acc_re_ff, acc_re_in;
   logic signed [AW-1:0]    acc_im_ff, acc_im_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   pwf_pkg::pwf_rsp_type    rsp_ff, rsp_in;

   logic                    mode_poly;
   logic [RAW-1:0]          push_addr;
   logic [FAW-1:0]          read_pos;
   logic [FAW-1:0]          fp_next_frame;
   logic [FAW-1:0]          j_frame;
   logic [TAW-1:0]          tap_last;
   logic                    acc_clear;
   logic                    finish;

   logic                    ring_we;
   logic [RAW-1:0]          ring_waddr;
   logic [2*SW-1:0]         ring_wdata;
   logic                    rd_en;
   logic [RAW-1:0]          ring_raddr;
   logic [2*SW-1:0]         ring_rdata;
   logic                    win_we;
   logic [RAW-1:0]          win_raddr;
   logic [SW-1:0]           win_rdata;
   logic signed [SW-1:0]    samp_re;
   logic signed [SW-1:0]    samp_im;
   logic signed [SW-1:0]    weight;

   // The ring wraps at the full length only in polyphase mode.
   assign mode_poly = frame_mode[1];
   assign push_addr = mode_poly ? fp_ff : RAW'(fp_ff[FAW-1:0]);
   assign read_pos  = queue.cmd.addr[FAW-1:0];
   assign tap_last  = rpoly_ff ? TAW'(pwf_pkg::TAPS - 1) : '0;

   // Pointer arithmetic that wraps at one frame.
   assign fp_next_frame = push_addr[FAW-1:0] + 1'b1;
   assign j_frame       = fp_ff[FAW-1:0] + read_pos;

   // Tap addresses: taps sit one frame apart in both ring and window table.
   assign ring_raddr = {j_ff[RAW-1:FAW] + tap_ff, j_ff[FAW-1:0]};
   assign win_raddr  = {tap_ff, pos_ff};

   // Sequencer: next state and memory controls.
   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      fp_in           = fp_ff;
      tap_in          = tap_ff;
      j_in            = j_ff;
      pos_in          = pos_ff;
      raw_in          = raw_ff;
      rpoly_in        = rpoly_ff;
      rd_v_in         = 1'b0;
      acc_clear       = 1'b0;
      finish          = 1'b0;
      status.pop      = 1'b0;
      status.clearing = 1'b0;
      ring_we         = 1'b0;
      ring_waddr      = push_addr;
      ring_wdata      = {queue.cmd.data_re, queue.cmd.data_im};
      win_we          = 1'b0;
      rd_en           = 1'b0;
      unique case (state_ff)
         pwf_pkg::ST_CLEAR: begin
            status.clearing = 1'b1;
            ring_we         = 1'b1;
            ring_waddr      = clr_ff;
            ring_wdata      = '0;
            clr_in          = clr_ff + 1'b1;
            if (clr_ff == RAW'(pwf_pkg::RING_LEN - 1)) begin
               state_in = pwf_pkg::ST_IDLE;
            end
         end
         pwf_pkg::ST_IDLE: begin
            if (queue.valid) begin
               status.pop = 1'b1;
               unique case (queue.cmd.kind)
                  pwf_pkg::KIND_PUSH: begin
                     ring_we = 1'b1;
                     if (mode_poly) begin
                        fp_in = push_addr + 1'b1;
                     end else begin
                        fp_in = RAW'(fp_next_frame);
                     end
                  end
                  pwf_pkg::KIND_COEF: begin
                     win_we = 1'b1;
                  end
                  pwf_pkg::KIND_READ: begin
                     if (mode_poly) begin
                        j_in = fp_ff + RAW'(read_pos);
                     end else begin
                        j_in = RAW'(j_frame);
                     end
                     pos_in    = read_pos;
                     raw_in    = (frame_mode == pwf_pkg::MODE_RAW);
                     rpoly_in  = mode_poly;
                     tap_in    = '0;
                     acc_clear = 1'b1;
                     state_in  = pwf_pkg::ST_ISSUE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         pwf_pkg::ST_ISSUE: begin
            rd_en   = 1'b1;
            rd_v_in = 1'b1;
            tap_in  = tap_ff + 1'b1;
            if (tap_ff == tap_last) begin
               state_in = pwf_pkg::ST_FLUSH;
            end
         end
         pwf_pkg::ST_FLUSH: begin
            if (!rd_v_ff && !prod_v_ff) begin
               finish   = 1'b1;
               state_in = pwf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pwf_pkg::ST_IDLE;
         end
      endcase
   end

   // Ring memory: real part in the upper half, imaginary in the lower.
   pwf_ram #(
      .WIDTH (2 * SW),
      .DEPTH (pwf_pkg::RING_LEN)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_en   (rd_en),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   // Window coefficient table.
   pwf_ram #(
      .WIDTH (SW),
      .DEPTH (pwf_pkg::RING_LEN)
   ) u_window (
      .clock   (clock),
      .wr_en   (win_we),
      .wr_addr (queue.cmd.addr),
      .wr_data (queue.cmd.data_re),
      .rd_en   (rd_en),
      .rd_addr (win_raddr),
      .rd_data (win_rdata)
   );

   assign samp_re = ring_rdata[2*SW-1:SW];
   assign samp_im = ring_rdata[SW-1:0];
   assign weight  = win_rdata;

   // Multiply stage. Raw mode scales the sample so that rounding returns it.
   always_comb begin
      prod_v_in = rd_v_ff;
      if (raw_ff) begin
         prod_re_in = PW'(samp_re) <<< pwf_pkg::ROUND_SHIFT;
         prod_im_in = PW'(samp_im) <<< pwf_pkg::ROUND_SHIFT;
      end else begin
         prod_re_in = samp_re * weight;
         prod_im_in = samp_im * weight;
      end
   end

   // Accumulate stage and result register.
   always_comb begin
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (acc_clear) begin
         acc_re_in = '0;
         acc_im_in = '0;
      end else if (prod_v_ff) begin
         acc_re_in = acc_re_ff + AW'(prod_re_ff);
         acc_im_in = acc_im_ff + AW'(prod_im_ff);
      end
      rsp_valid_in = finish;
      rsp_in       = rsp_ff;
      if (finish) begin
         rsp_in.out_re       = pwf_round_sat(acc_re_ff);
         rsp_in.out_im       = pwf_round_sat(acc_im_ff);
         rsp_in.out_position = pos_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pwf_pkg::ST_CLEAR;
         clr_ff       <= '0;
         fp_ff        <= '0;
         tap_ff       <= '0;
         rd_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fp_ff        <= fp_in;
         tap_ff       <= tap_in;
         rd_v_ff      <= rd_v_in;
         prod_v_ff    <= prod_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      j_ff       <= j_in;
      pos_ff     <= pos_in;
      raw_ff     <= raw_in;
      rpoly_ff   <= rpoly_in;
      prod_re_ff <= prod_re_in;
      prod_im_ff <= prod_im_in;
      acc_re_ff  <= acc_re_in;
      acc_im_ff  <= acc_im_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // A result strobe follows only the last cycle of a drained read.
   a_rsp_after_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == pwf_pkg::ST_FLUSH))
      else $error("result strobe without a finished read");

   // No command is taken while the ring is being cleared.
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pwf_pkg::ST_CLEAR) |-> !status.pop)
      else $error("command taken during ring clear");

   // Every tap read reaches the multiply stage in the next cycle.
   a_tap_to_prod: assert property (@(posedge clock) disable iff (reset)
      rd_v_ff |=> prod_v_ff)
      else $error("tap read lost before multiply");

endmodule

// ===== src/polyphase_window_framer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphase_window_framer_top: windowing front end of a spectrum analyzer
// Pushes complex samples into a ring, loads window coefficients and returns
// raw, windowed or eight-tap polyphase frame elements on request.
// ----------------------------------------------------------------------------
// A request transfers on a clock edge with start high and busy low. Requests
// pass through a four-entry queue to an execution unit that works on one at a
// time. A push or a coefficient write is handled directly in the idle state.
// In a read the ring and window memories, which each have one read port,
// deliver one tap per cycle into a multiply-accumulate pipeline. The result
// is shown for exactly one cycle with rsp_valid high, in the cycle after the
// read finishes; the receiver must take it then, as there is no back-pressure.
// After reset the ring is cleared to zero while busy stays high. Mode writes
// on the csr port are always taken (csr_ready is tied high) and are to be
// made only while no request is outstanding.
// ----------------------------------------------------------------------------
module polyphase_window_framer_top #(
   parameter int QUEUE_DEPTH = pwf_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  pwf_pkg::pwf_req_type       req_item,
   output logic                       rsp_valid,
   output pwf_pkg::pwf_rsp_type       rsp_item,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [pwf_pkg::MODE_W-1:0] csr_data
);

   logic [pwf_pkg::MODE_W-1:0]   frame_mode_ff, frame_mode_in;
   pwf_pkg::pwf_queue_type       queue;
   pwf_pkg::pwf_back_status_type status;

   // Frame mode register, written by a csr transfer.
   assign csr_ready     = 1'b1;
   assign frame_mode_in = (csr_valid && csr_ready) ? csr_data : frame_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_mode_ff <= pwf_pkg::MODE_WINDOW;
      end else begin
         frame_mode_ff <= frame_mode_in;
      end
   end

   // Request intake and queue.
   pwf_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .busy     (busy),
      .queue    (queue),
      .status   (status)
   );

   // Execution unit.
   pwf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .frame_mode (frame_mode_ff),
      .queue      (queue),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the polyphase window framer
// A shadow copy of the ring, the window table, the fill pointer and the frame
// mode follows every accepted request. Each read queues the frame element it
// should return, and a checker compares every strobed response against the
// oldest queued element. Directed tests cover reset contents, rounding,
// extreme values and every mode. Random traffic follows in phases, one frame
// mode per phase, with bursty request timing.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 80;
   localparam int ITEM_TARGET  = 1450;
   localparam int REPORT_LIMIT = 10;

   localparam int SW  = pwf_pkg::SAMPLE_W;
   localparam int MW  = pwf_pkg::MODE_W;
   localparam int RL  = pwf_pkg::RING_LEN;
   localparam int FS  = pwf_pkg::FRAME_SIZE;
   localparam int RAW = pwf_pkg::RING_AW;
   localparam int PSW = pwf_pkg::POS_W;
   localparam int OW  = pwf_pkg::OUT_W;

   // Codes that the package leaves unnamed.
   localparam logic [1:0]    OP_UNUSED       = 2'd3;
   localparam logic [MW-1:0] MODE_POLY_ALIAS = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   pwf_pkg::pwf_req_type  req_item = '0;
   logic                  rsp_valid;
   pwf_pkg::pwf_rsp_type  rsp_item;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [MW-1:0]         csr_data = '0;

   // Shadow state of the framer.
   bit signed [SW-1:0] ring_re_shadow [RL];
   bit signed [SW-1:0] ring_im_shadow [RL];
   bit signed [SW-1:0] window_shadow  [RL];
   bit                 window_loaded  [RL];
   int unsigned        fill_ptr_shadow = 0;
   logic [MW-1:0]      mode_shadow = pwf_pkg::MODE_WINDOW;

   pwf_pkg::pwf_rsp_type expected_elements [$];
   int                   error_count = 0;
   int                   items_sent = 0;
   int                   cycle_count = 0;
   int                   burst_left = 0;

   polyphase_window_framer_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Clock generation, 20 ns period.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Round a Q5.30 sum to Q5.15 with halves going up, then saturate.
   function automatic logic signed [OW-1:0] round_saturate(input longint sum);
      longint rounded;
      rounded = (sum + pwf_pkg::ROUND_HALF) >>> pwf_pkg::ROUND_SHIFT;
      if (rounded > pwf_pkg::OUT_MAX) rounded = pwf_pkg::OUT_MAX;
      if (rounded < pwf_pkg::OUT_MIN) rounded = pwf_pkg::OUT_MIN;
      return rounded[OW-1:0];
   endfunction

   // Apply an accepted request to the shadow framer. A read queues the element
   // that the block should return for it.
   function automatic void shadow_request(input pwf_pkg::pwf_req_type item);
      int unsigned          len;
      int unsigned          slot;
      int unsigned          pos;
      int unsigned          base;
      int unsigned          taps;
      int unsigned          k;
      longint               acc_re;
      longint               acc_im;
      pwf_pkg::pwf_rsp_type element;
      len = mode_shadow[1] ? RL : FS;
      case (item.op)
         pwf_pkg::OP_PUSH: begin
            slot = fill_ptr_shadow % len;
            ring_re_shadow[slot] = item.sample_re;
            ring_im_shadow[slot] = item.sample_im;
            fill_ptr_shadow = (slot + 1) % len;
         end
         pwf_pkg::OP_COEF: begin
            window_shadow[item.coef_index] = item.coef_value;
            window_loaded[item.coef_index] = 1'b1;
         end
         pwf_pkg::OP_READ: begin
            pos  = item.frame_index % FS;
            base = (fill_ptr_shadow % len + pos) % len;
            if (mode_shadow == pwf_pkg::MODE_RAW) begin
               acc_re = ring_re_shadow[base];
               acc_im = ring_im_shadow[base];
               element.out_re = acc_re[OW-1:0];
               element.out_im = acc_im[OW-1:0];
            end else begin
               // Windowed mode is the one-tap case of the polyphase sum.
               taps = mode_shadow[1] ? pwf_pkg::TAPS : 1;
               acc_re = 0;
               acc_im = 0;
               for (k = 0; k < taps; k++) begin
                  slot = (base + k * FS) % RL;
                  acc_re += longint'(ring_re_shadow[slot])
                            * longint'(window_shadow[pos + k * FS]);
                  acc_im += longint'(ring_im_shadow[slot])
                            * longint'(window_shadow[pos + k * FS]);
               end
               element.out_re = round_saturate(acc_re);
               element.out_im = round_saturate(acc_im);
            end
            element.out_position = pos[PSW-1:0];
            expected_elements.push_back(element);
         end
         default: ;
      endcase
   endfunction

   // Sample value biased toward the extremes.
   function automatic logic signed [SW-1:0] random_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '0;
         default: return SW'($urandom);
      endcase
   endfunction

   // Request with every field random; callers set the fields that matter.
   function automatic pwf_pkg::pwf_req_type random_request();
      pwf_pkg::pwf_req_type item;
      item.op          = 2'($urandom);
      item.sample_re   = random_sample();
      item.sample_im   = random_sample();
      item.coef_index  = RAW'($urandom);
      item.coef_value  = random_sample();
      item.frame_index = PSW'($urandom);
      return item;
   endfunction

   // Send one request. The sender works in bursts with random gaps between.
   task automatic send_item(input pwf_pkg::pwf_req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start    <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      shadow_request(item);
      items_sent++;
   endtask

   // Send a push of the given sample.
   task automatic push_sample(input logic signed [SW-1:0] re,
                              input logic signed [SW-1:0] im);
      pwf_pkg::pwf_req_type item;
      item = random_request();
      item.op = pwf_pkg::OP_PUSH;
      item.sample_re = re;
      item.sample_im = im;
      send_item(item);
   endtask

   // Send a coefficient write.
   task automatic write_coef(input logic [RAW-1:0] index,
                             input logic signed [SW-1:0] value);
      pwf_pkg::pwf_req_type item;
      item = random_request();
      item.op = pwf_pkg::OP_COEF;
      item.coef_index = index;
      item.coef_value = value;
      send_item(item);
   endtask

   // Read one frame element. Any window entry the read would use that has
   // never been written is loaded first with a random coefficient.
   task automatic read_frame(input logic [PSW-1:0] pos);
      int                   taps;
      int                   k;
      pwf_pkg::pwf_req_type item;
      if (mode_shadow == pwf_pkg::MODE_RAW) taps = 0;
      else taps = mode_shadow[1] ? pwf_pkg::TAPS : 1;
      for (k = 0; k < taps; k++) begin
         if (!window_loaded[pos + k * FS])
            write_coef(RAW'(pos + k * FS), random_sample());
      end
      item = random_request();
      item.op = pwf_pkg::OP_READ;
      item.frame_index = pos;
      send_item(item);
   endtask

   // Wait until every expected element has come back, then let the block
   // finish any push or coefficient write still in flight.
   task automatic wait_idle();
      start <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_elements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Change the frame mode while the block is idle.
   task automatic write_frame_mode(input logic [MW-1:0] mode);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      mode_shadow = mode;
   endtask

   // Compare each strobed response against the oldest expected element.
   always @(posedge clock) begin
      pwf_pkg::pwf_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_elements.size() == 0) begin
            if (error_count < REPORT_LIMIT)
               $display("unexpected response: re=%0d im=%0d pos=%0d",
                        rsp_item.out_re, rsp_item.out_im, rsp_item.out_position);
            error_count++;
         end else begin
            want = expected_elements.pop_front();
            if (rsp_item.out_re !== want.out_re || rsp_item.out_im !== want.out_im
                || rsp_item.out_position !== want.out_position) begin
               if (error_count < REPORT_LIMIT)
                  $display("mismatch: expected re=%0d im=%0d pos=%0d, got re=%0d im=%0d pos=%0d",
                           want.out_re, want.out_im, want.out_position,
                           rsp_item.out_re, rsp_item.out_im, rsp_item.out_position);
               error_count++;
            end
         end
      end
   end

   // The ring must read back as zero after reset, in the reset windowed mode.
   task automatic test_reset_contents();
      write_coef(RAW'(0), 16'sh7fff);
      write_coef(RAW'(FS - 1), 16'sh8000);
      read_frame(PSW'(0));
      read_frame(PSW'(FS - 1));
   endtask

   // Windowed products at full scale, and rounding of exact halves upward.
   task automatic test_windowed_rounding();
      push_sample(16'sh8000, 16'sh7fff);
      push_sample(16'sh0001, -16'sh0001);
      write_coef(RAW'(FS - 2), 16'sh8000);
      write_coef(RAW'(FS - 1), 16'sh4000);
      read_frame(PSW'(FS - 2));
      read_frame(PSW'(FS - 1));
   endtask

   // The unused operation must produce nothing.
   task automatic test_unused_op();
      pwf_pkg::pwf_req_type item;
      item = random_request();
      item.op = OP_UNUSED;
      send_item(item);
   endtask

   // Raw mode passes ring samples through unchanged, the newest and the oldest.
   task automatic test_raw_mode();
      write_frame_mode(pwf_pkg::MODE_RAW);
      read_frame(PSW'(FS - 2));
      read_frame(PSW'(FS - 1));
      read_frame(PSW'(0));
   endtask

   // Polyphase sum whose last tap wraps around the ring onto the first
   // sample; mode three must behave the same as polyphase mode.
   task automatic test_polyphase_mode();
      write_frame_mode(pwf_pkg::MODE_POLY);
      read_frame(PSW'(FS - 2));
      write_frame_mode(MODE_POLY_ALIAS);
      read_frame(PSW'(FS - 2));
   endtask

   // Random traffic in phases, one frame mode per phase.
   task automatic test_random_traffic();
      int                   phase;
      int                   phase_end;
      int                   roll;
      logic [MW-1:0]        mode;
      pwf_pkg::pwf_req_type item;
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase)
            0: mode = pwf_pkg::MODE_POLY;
            1: mode = pwf_pkg::MODE_RAW;
            2: mode = MODE_POLY_ALIAS;
            3: mode = pwf_pkg::MODE_WINDOW;
            default: mode = MW'($urandom_range(0, 3));
         endcase
         write_frame_mode(mode);
         phase_end = items_sent + $urandom_range(80, 200);
         while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
               push_sample(random_sample(), random_sample());
            end else if (roll < 60) begin
               write_coef(RAW'($urandom), random_sample());
            end else if (roll < 95) begin
               read_frame(PSW'($urandom));
            end else begin
               item = random_request();
               item.op = OP_UNUSED;
               send_item(item);
            end
         end
         phase++;
      end
   endtask

   // Test sequence.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Let the ring clearing pass finish before anything else.
      while (busy) @(posedge clock);
      test_reset_contents();
      test_windowed_rounding();
      test_unused_op();
      test_raw_mode();
      test_polyphase_mode();
      test_random_traffic();
      wait_idle();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
